// File: sv/udc_pkg.sv
// Shared types, constants and the ones-complement adder for the UDP deframer.
// Depends on nothing; the verdict stage and the top level refer to it by scoped names.
`default_nettype none

package udc_pkg;

    // Default upper bound on the number of bytes in one datagram.
    localparam int MAX_DATAGRAM_DEF = 65535;
    // Length of the UDP header in bytes.
    localparam int HDR_LEN = 8;
    // Width used when comparing the byte count with the 16-bit length field.
    localparam int LEN_CMP_W = 17;
    // Protocol number that enters the pseudo header.
    localparam logic [15:0] UDP_PROTO = 16'd17;
    // A computed checksum of zero is sent as all ones.
    localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_LEN_OVER = 3'd2,
        ST_OVERSIZE = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } rx_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        end_of_packet;
        status_t     status;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } tx_item_t;

    // Handed from the byte stage to the verdict stage.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        end_of_packet;
        status_t     status;    // verdict when no checksum compare is needed
        logic        check;     // compare the checksum to form the verdict
        logic [15:0] sum;       // folded sum of pseudo header, header and payload
        logic [15:0] pad;       // padded odd last payload byte, or zero
        logic [15:0] checksum;  // checksum field from the header
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } stage_t;

    // 16-bit ones-complement add with the end-around carry folded back in.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

// File: sv/udc_stream_if.sv
// Valid/ready stream channel used for the byte input and the result output.
// The payload type is set per instance from the types in udc_pkg.
`default_nettype none

interface udc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/udc_verdict.sv
// Output stage of the UDP deframer: final checksum fold, compare and result register.
// Depends on udc_pkg and the udc_stream_if channel.
`default_nettype none

module udc_verdict (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  udc_pkg::stage_t    s1,
    output logic               s1_ready,
    udc_stream_if.source       tx
);

    logic               out_valid_reg;
    udc_pkg::tx_item_t  out_reg;
    udc_pkg::tx_item_t  out_next;
    logic [15:0]        total;
    logic [15:0]        ck;

    assign s1_ready = !out_valid_reg || tx.ready;

    always_comb
    begin
        total = udc_pkg::ones_add(s1.sum, s1.pad);
        ck    = ~total;
        if (ck == 16'h0000)
        begin
            ck = udc_pkg::CSUM_ALL_ONES;
        end
        out_next.payload_valid = s1.payload_valid;
        out_next.payload_byte  = s1.payload_byte;
        out_next.end_of_packet = s1.end_of_packet;
        out_next.src_port      = s1.src_port;
        out_next.dst_port      = s1.dst_port;
        if (s1.check)
        begin
            out_next.status = (ck == s1.checksum) ? udc_pkg::ST_OK : udc_pkg::ST_MISMATCH;
        end
        else
        begin
            out_next.status = s1.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign tx.valid   = out_valid_reg;
    assign tx.payload = out_reg;

    // Only the end-of-packet result carries a verdict and the ports.
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.end_of_packet) |->
        (out_reg.status == udc_pkg::ST_OK && out_reg.src_port == 16'h0000
         && out_reg.dst_port == 16'h0000))
        else $error("verdict fields set on a result that is not end of packet");

    // Every presented result carries a payload byte or closes a packet.
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.payload_valid || out_reg.end_of_packet))
        else $error("empty result presented");

endmodule

`default_nettype wire

// File: sv/udp_deframer_checksum_check.sv
// Top level of the UDP deframer with pseudo-header checksum check.
// Depends on udc_pkg, udc_stream_if and udc_verdict.
//
// Usage: datagram bytes enter on rx, header first, one byte per transfer, with
// last_byte set on the final byte. The IPv4 source and destination addresses are
// taken from the first transfer of a datagram. Each payload byte inside the
// encoded length produces one transfer on tx; the final byte produces a transfer
// with end_of_packet set, the status and the two ports. Header bytes and trailing
// bytes past the length produce nothing. Payload leaves before the verdict, so a
// receiver drops the buffered payload when the status is not ok.
// Pipeline: the result of an accepted byte is registered in the stage register
// and then in the output register. One byte is accepted every cycle unless
// rx.ready drops on a tx stall; the running sum is a single 16-bit
// end-around-carry add per byte, and the pseudo header words are folded in
// during the eight header bytes so the end of packet needs only one more fold
// and a compare in the output stage.
// Reset clears the byte count, the sum, the captured header fields and both
// pipeline stages. When tx stalls, the stage register fills and rx.ready drops
// only while both stages hold results; bytes that produce no result pass freely
// while the stage register is free.
`default_nettype none

module udp_deframer_checksum_check #(
    parameter int MAX_DATAGRAM = udc_pkg::MAX_DATAGRAM_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    udc_stream_if.sink    rx,
    udc_stream_if.source  tx
);

    // The byte count saturates at MAX_DATAGRAM + 1 to flag oversize datagrams.
    localparam int CW = $clog2(MAX_DATAGRAM + 2);
    localparam int LW = udc_pkg::LEN_CMP_W;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      idx;
    logic [15:0]        sum_reg;
    logic [15:0]        sum_next;
    logic [15:0]        word;
    logic [7:0]         hold_reg;
    logic [7:0]         hold_next;
    logic [15:0]        len_reg;
    logic [15:0]        len_next;
    logic [15:0]        csum_reg;
    logic [15:0]        csum_next;
    logic [15:0]        src_port_reg;
    logic [15:0]        src_port_next;
    logic [15:0]        dst_port_reg;
    logic [15:0]        dst_port_next;
    logic [63:0]        addrs_reg;
    logic [63:0]        addrs_next;
    logic [7:0]         b;
    logic               last;
    logic               in_range;
    logic               pay_valid;
    logic               emit;
    logic               over;
    logic               short_cnt;
    logic               len_over;
    logic               len_short;
    udc_pkg::status_t   pre_status;
    udc_pkg::stage_t    s1_reg;
    udc_pkg::stage_t    s1_next;
    logic               s1_valid_reg;
    logic               s1_ready;
    logic               rx_fire;

    assign rx.ready = !s1_valid_reg || s1_ready;
    assign rx_fire  = rx.valid && rx.ready;

    // Byte stage: header capture, running sum and the early part of the verdict.
    always_comb
    begin
        b    = rx.payload.data_byte;
        last = rx.payload.last_byte;
        idx  = count_reg;

        count_next    = count_reg;
        sum_next      = sum_reg;
        hold_next     = hold_reg;
        len_next      = len_reg;
        csum_next     = csum_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        addrs_next    = addrs_reg;
        word          = 16'h0000;
        pay_valid     = 1'b0;

        in_range = idx < CW'(MAX_DATAGRAM);

        if (idx == '0)
        begin
            addrs_next = {rx.payload.src_addr, rx.payload.dst_addr};
        end

        // The pseudo header words are spread over the header bytes, one per byte.
        // The length enters twice, which in ones-complement arithmetic is a
        // rotate left by one bit.
        if (idx < CW'(udc_pkg::HDR_LEN))
        begin
            unique case (idx[2:0])
                3'd0:
                begin
                    src_port_next = {b, 8'h00};
                    word          = udc_pkg::UDP_PROTO;
                end
                3'd1:
                begin
                    src_port_next = {src_port_reg[15:8], b};
                    word          = src_port_next;
                end
                3'd2:
                begin
                    dst_port_next = {b, 8'h00};
                    word          = addrs_reg[63:48];
                end
                3'd3:
                begin
                    dst_port_next = {dst_port_reg[15:8], b};
                    word          = dst_port_next;
                end
                3'd4:
                begin
                    len_next = {b, 8'h00};
                    word     = addrs_reg[47:32];
                end
                3'd5:
                begin
                    len_next = {len_reg[15:8], b};
                    word     = addrs_reg[31:16];
                end
                3'd6:
                begin
                    csum_next = {b, 8'h00};
                    word      = addrs_reg[15:0];
                end
                3'd7:
                begin
                    csum_next = {csum_reg[15:8], b};
                    word      = {len_reg[14:0], len_reg[15]};
                end
                default:
                begin
                    word = 16'h0000;
                end
            endcase
        end
        else if (in_range && (LW'(idx) < LW'(len_reg)))
        begin
            pay_valid = 1'b1;
            if (!idx[0])
            begin
                hold_next = b;
            end
            else
            begin
                word = {hold_reg, b};
            end
        end

        sum_next   = udc_pkg::ones_add(sum_reg, word);
        count_next = (idx > CW'(MAX_DATAGRAM)) ? idx : idx + CW'(1);

        over      = count_next > CW'(MAX_DATAGRAM);
        short_cnt = count_next < CW'(udc_pkg::HDR_LEN);
        len_over  = LW'(len_next) > LW'(count_next);
        len_short = len_next < 16'(udc_pkg::HDR_LEN);

        if (over)
        begin
            pre_status = udc_pkg::ST_OVERSIZE;
        end
        else if (short_cnt)
        begin
            pre_status = udc_pkg::ST_SHORT;
        end
        else if (len_over)
        begin
            pre_status = udc_pkg::ST_LEN_OVER;
        end
        else if (len_short)
        begin
            pre_status = udc_pkg::ST_SHORT;
        end
        else
        begin
            pre_status = udc_pkg::ST_OK;
        end

        emit = pay_valid || last;

        s1_next.payload_valid = pay_valid;
        s1_next.payload_byte  = pay_valid ? b : 8'h00;
        s1_next.end_of_packet = last;
        s1_next.status        = last ? pre_status : udc_pkg::ST_OK;
        s1_next.check         = last && !(over || short_cnt || len_over || len_short);
        s1_next.sum           = sum_next;
        s1_next.pad           = len_next[0] ? {hold_next, 8'h00} : 16'h0000;
        s1_next.checksum      = csum_next;
        s1_next.src_port      = last ? src_port_next : 16'h0000;
        s1_next.dst_port      = last ? dst_port_next : 16'h0000;

        // The last byte closes the datagram and starts the next one from scratch.
        if (last)
        begin
            count_next    = '0;
            sum_next      = 16'h0000;
            hold_next     = 8'h00;
            len_next      = 16'h0000;
            csum_next     = 16'h0000;
            src_port_next = 16'h0000;
            dst_port_next = 16'h0000;
            addrs_next    = 64'h0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= 16'h0000;
            hold_reg     <= 8'h00;
            len_reg      <= 16'h0000;
            csum_reg     <= 16'h0000;
            src_port_reg <= 16'h0000;
            dst_port_reg <= 16'h0000;
            addrs_reg    <= 64'h0;
        end
        else if (rx_fire)
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            hold_reg     <= hold_next;
            len_reg      <= len_next;
            csum_reg     <= csum_next;
            src_port_reg <= src_port_next;
            dst_port_reg <= dst_port_next;
            addrs_reg    <= addrs_next;
        end
    end

    // Stage register between the byte stage and the verdict stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_fire)
        begin
            s1_valid_reg <= emit;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    udc_verdict u_verdict (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1       (s1_reg),
        .s1_ready (s1_ready),
        .tx       (tx)
    );

    // The byte count never passes its saturation value.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_DATAGRAM + 1))
        else $error("byte count beyond saturation");

    // A last byte leaves the per-datagram state cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && rx.payload.last_byte) |=>
        (count_reg == '0 && sum_reg == 16'h0000 && len_reg == 16'h0000))
        else $error("datagram state not cleared after last byte");

    // A byte that yields no result leaves the stage register empty.
    a_no_result_no_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && !emit) |=> !s1_valid_reg)
        else $error("stage register filled by a byte without result");

endmodule

`default_nettype wire
